FILE: hdl/enn_pkg.sv
`default_nettype none
package enn_pkg;

	localparam int unsigned STATUS_W = 3;
	localparam int unsigned EXP_W    = 10;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEG  = 3'd0,
		ST_ZERO = 3'd1,
		ST_IN   = 3'd2,
		ST_CONV = 3'd3,
		ST_INV  = 3'd4
	} status_t;

	// double bit patterns of the range bounds (positive values order as integers)
	localparam logic [63:0] ONE_BITS      = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] THOUSAND_BITS = 64'h408F_4000_0000_0000;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	function automatic logic [7:0] si_prefix(input logic signed [EXP_W-1:0] e);
		logic [7:0] c;
		c = CHAR_SPACE;
		case (e)
			-10'sd24: c = "y";
			-10'sd21: c = "z";
			-10'sd18: c = "a";
			-10'sd15: c = "f";
			-10'sd12: c = "p";
			-10'sd9:  c = "n";
			-10'sd6:  c = "u";
			-10'sd3:  c = "m";
			10'sd3:   c = "k";
			10'sd6:   c = "M";
			10'sd9:   c = "G";
			10'sd12:  c = "T";
			10'sd15:  c = "P";
			10'sd18:  c = "E";
			10'sd21:  c = "Z";
			10'sd24:  c = "Y";
			default:  c = CHAR_SPACE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/engineering_notation_normalizer_unit.sv
// channel   | ports                                          | transfer
// ----------+------------------------------------------------+--------------------
// command   | start, busy, value_bits                        | start & !busy
// result    | done, status, mantissa_bits, decimal_exponent, | done, one cycle,
//           | prefix_char                                    | cannot be held off
//
// special values, zero and values in [1,1000) give done in the cycle after the transfer.
// a conversion runs m multiply-by-ten steps or d divide-by-ten steps, each divide-by-ten
// step made of radix-256 divide-by-five steps, a rounding step and a loop decision.
// for a conversion, busy stays high from the transfer until done; arst_n clears the sequencer at once.
`default_nettype none
module engineering_notation_normalizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] value_bits,
	output logic             done,
	output logic [2:0]       status,
	output logic [63:0]      mantissa_bits,
	output logic signed [9:0] decimal_exponent,
	output logic [7:0]       prefix_char
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOP = 4'b0010,
		S_DIV  = 4'b0100,
		S_DIVR = 4'b1000
	} state_t;

	state_t state_q;
	logic [63:0] x_q;
	logic signed [9:0] e_q;
	logic [1:0] m3_q;
	logic up_q;
	logic [63:0] d_q;
	logic [2:0] rem_q;
	logic [2:0] cnt_q;

	// multiply by ten with round to nearest even
	logic [10:0] m_be, m_be_base, m_be_new, m_field;
	logic [52:0] m_sig, m_mant, m_mant_f;
	logic [56:0] m_p;
	logic [2:0] m_s;
	logic m_rnd, m_stk;
	logic [53:0] m_sum;
	logic [63:0] mul_res;

	always_comb begin
		m_be = x_q[62:52];
		m_sig = {(m_be != 11'd0), x_q[51:0]};
		m_p = {1'b0, m_sig, 3'b000} + {3'b000, m_sig, 1'b0};
		if (m_p[56]) begin
			m_s = 3'd4; m_mant = m_p[56:4]; m_rnd = m_p[3]; m_stk = |m_p[2:0];
		end else if (m_p[55]) begin
			m_s = 3'd3; m_mant = m_p[55:3]; m_rnd = m_p[2]; m_stk = |m_p[1:0];
		end else if (m_p[54]) begin
			m_s = 3'd2; m_mant = m_p[54:2]; m_rnd = m_p[1]; m_stk = m_p[0];
		end else if (m_p[53]) begin
			m_s = 3'd1; m_mant = m_p[53:1]; m_rnd = m_p[0]; m_stk = 1'b0;
		end else begin
			m_s = 3'd0; m_mant = m_p[52:0]; m_rnd = 1'b0; m_stk = 1'b0;
		end
		m_sum = {1'b0, m_mant} + 54'(m_rnd & (m_stk | m_mant[0]));
		m_mant_f = m_sum[53] ? m_sum[53:1] : m_sum[52:0];
		m_be_base = (m_be == 11'd0) ? 11'd1 : m_be;
		m_be_new = m_be_base + 11'(m_s) + 11'(m_sum[53]);
		// subnormal result keeps a zero exponent field
		m_field = m_mant_f[52] ? m_be_new : 11'd0;
		mul_res = {1'b0, m_field, m_mant_f[51:0]};
	end

	// divide by five, eight quotient bits a cycle
	logic [2:0] dv_r;
	logic [3:0] dv_t;
	logic [7:0] dv_q;

	always_comb begin
		dv_r = rem_q;
		dv_q = 8'd0;
		dv_t = 4'd0;
		for (int i = 0; i < 8; i++) begin
			dv_t = {dv_r, d_q[63-i]};
			if (dv_t >= 4'd5) begin
				dv_q[7-i] = 1'b1;
				dv_r = 3'(dv_t - 4'd5);
			end else begin
				dv_r = dv_t[2:0];
			end
		end
	end

	// round the quotient of (m << 11) / 5 back to a double
	logic [52:0] r_mant, r_mant_f;
	logic r_rnd, r_stk;
	logic [53:0] r_sum;
	logic [10:0] r_be_new;
	logic [63:0] div_res;

	always_comb begin
		if (d_q[61]) begin
			r_mant = d_q[61:9]; r_rnd = d_q[8]; r_stk = (|d_q[7:0]) | (rem_q != 3'd0);
		end else begin
			r_mant = d_q[60:8]; r_rnd = d_q[7]; r_stk = (|d_q[6:0]) | (rem_q != 3'd0);
		end
		r_sum = {1'b0, r_mant} + 54'(r_rnd & (r_stk | r_mant[0]));
		r_mant_f = r_sum[53] ? r_sum[53:1] : r_sum[52:0];
		r_be_new = x_q[62:52] - (d_q[61] ? 11'd3 : 11'd4) + 11'(r_sum[53]);
		div_res = {1'b0, r_be_new, r_mant_f[51:0]};
	end

	logic need;
	logic [1:0] m3_next;
	assign need = (m3_q != 2'd0) || (up_q ? (x_q >= enn_pkg::THOUSAND_BITS)
	                                      : (x_q < enn_pkg::ONE_BITS));
	assign m3_next = (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (value_bits[62:52] == 11'h7FF) begin
							done <= 1'b1;
						end else if (value_bits[62:0] == 63'd0) begin
							done <= 1'b1;
						end else if (value_bits[63]) begin
							done <= 1'b1;
						end else if (value_bits >= enn_pkg::ONE_BITS &&
						             value_bits < enn_pkg::THOUSAND_BITS) begin
							done <= 1'b1;
						end else begin
							state_q <= S_LOOP;
						end
					end
				end
				S_LOOP: begin
					if (!need) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (up_q) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == 3'd7) begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: state_q <= S_LOOP;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q <= value_bits;
				e_q <= '0;
				m3_q <= 2'd0;
				up_q <= (value_bits >= enn_pkg::THOUSAND_BITS);
				decimal_exponent <= '0;
				prefix_char <= enn_pkg::CHAR_SPACE;
				if (value_bits[62:52] == 11'h7FF) begin
					status <= enn_pkg::ST_INV;
					mantissa_bits <= '0;
				end else if (value_bits[62:0] == 63'd0) begin
					status <= enn_pkg::ST_ZERO;
					mantissa_bits <= value_bits;
				end else if (value_bits[63]) begin
					status <= enn_pkg::ST_NEG;
					mantissa_bits <= '0;
				end else begin
					status <= enn_pkg::ST_IN;
					mantissa_bits <= value_bits;
				end
			end
			S_LOOP: begin
				if (!need) begin
					status <= enn_pkg::ST_CONV;
					mantissa_bits <= x_q;
					decimal_exponent <= e_q;
					prefix_char <= enn_pkg::si_prefix(e_q);
				end else if (up_q) begin
					d_q <= {1'b1, x_q[51:0], 11'd0};
					rem_q <= 3'd0;
					cnt_q <= 3'd0;
				end else begin
					x_q <= mul_res;
					e_q <= e_q - 10'sd1;
					m3_q <= m3_next;
				end
			end
			S_DIV: begin
				d_q <= {d_q[55:0], dv_q};
				rem_q <= dv_r;
				cnt_q <= cnt_q + 3'd1;
			end
			S_DIVR: begin
				x_q <= div_res;
				e_q <= e_q + 10'sd1;
				m3_q <= m3_next;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/enn_checker.sv
`default_nettype none
module enn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [63:0] mantissa_bits,
	input wire logic [9:0]  decimal_exponent
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("transfer lost");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= 3'd4)) else $error("bad status");

	a_exp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != enn_pkg::ST_CONV) |-> (decimal_exponent == 10'd0))
		else $error("exponent without conversion");

	a_neg_mant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == enn_pkg::ST_NEG || status == enn_pkg::ST_INV))
		|-> (mantissa_bits == 64'd0)) else $error("rejected value has mantissa");

endmodule

bind engineering_notation_normalizer_unit enn_checker u_enn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.mantissa_bits(mantissa_bits),
	.decimal_exponent(decimal_exponent)
);
`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		enn_pkg::status_t  st;
		logic [63:0]       mant;
		logic signed [9:0] ex;
		logic [7:0]        pfx;
	} eng_result_t;

	class eng_scoreboard;
		eng_result_t pending_q[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		task report(input string what, input logic [63:0] got, input logic [63:0] want);
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function string prefix_of(input int e);
			string tbl;
			tbl = "yzafpnum kMGTPEZY";
			if (e < -24 || e > 24 || (e % 3) != 0) return " ";
			return tbl.substr((e + 24) / 3, (e + 24) / 3);
		endfunction

		// rescale by repeated double steps, then align exponent to a multiple of three
		function void note_transfer(input logic [63:0] b);
			eng_result_t r;
			real x;
			int e;
			string p;
			r.mant = '0;
			r.ex = '0;
			r.pfx = enn_pkg::CHAR_SPACE;
			e = 0;
			if (b[62:52] == 11'h7FF) r.st = enn_pkg::ST_INV;
			else if (b[62:0] == '0) begin
				r.st = enn_pkg::ST_ZERO;
				r.mant = b;
			end else if (b[63]) r.st = enn_pkg::ST_NEG;
			else begin
				x = $bitstoreal(b);
				if (x >= 1.0 && x < 1000.0) begin
					r.st = enn_pkg::ST_IN;
					r.mant = b;
				end else begin
					r.st = enn_pkg::ST_CONV;
					if (x >= 1000.0) begin
						while (x >= 1000.0) begin x = x / 10.0; e++; end
						while (e % 3 != 0) begin x = x / 10.0; e++; end
					end else begin
						while (x < 1.0) begin x = x * 10.0; e--; end
						while (e % 3 != 0) begin x = x * 10.0; e--; end
					end
					r.mant = $realtobits(x);
					r.ex = e[9:0];
					p = prefix_of(e);
					r.pfx = p[0];
				end
			end
			pending_q.push_back(r);
		endfunction

		task check_result(input logic [2:0] st, input logic [63:0] mant,
				input logic [9:0] ex, input logic [7:0] pfx);
			eng_result_t w;
			if (pending_q.size() == 0) begin
				report("unexpected result", {61'd0, st}, '0);
				return;
			end
			w = pending_q.pop_front();
			if (st !== w.st) report("status", {61'd0, st}, {61'd0, w.st});
			if (mant !== w.mant) report("mantissa_bits", mant, w.mant);
			if (ex !== w.ex) report("decimal_exponent", {54'd0, ex}, {54'd0, w.ex});
			if (pfx !== w.pfx) report("prefix_char", {56'd0, pfx}, {56'd0, w.pfx});
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [63:0]       value_bits;
	logic              done;
	logic [2:0]        status;
	logic [63:0]       mantissa_bits;
	logic signed [9:0] decimal_exponent;
	logic [7:0]        prefix_char;

	eng_scoreboard sb;
	int            idle_pct;
	int            quiet_cycles;

	engineering_notation_normalizer_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .value_bits(value_bits),
		.done(done), .status(status), .mantissa_bits(mantissa_bits),
		.decimal_exponent(decimal_exponent), .prefix_char(prefix_char)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n && done) sb.check_result(status, mantissa_bits, decimal_exponent, prefix_char);
	end

	// watchdog on cycles without any transfer or result
	always @(negedge clk) begin
		if (!arst_n || done || (start && !busy)) quiet_cycles = 0;
		else if (++quiet_cycles >= 12000) begin
			$display("status: fail");
			$finish;
		end
	end

	// called just after a rising edge; returns at the edge of the transfer
	task send_value(input logic [63:0] v);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value_bits <= v;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		sb.note_transfer(v);
	endtask

	task drain();
		start <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(99) < 65) begin
			// mostly positive values within about fifteen decades of one
			v[63] = ($urandom_range(9) == 0);
			v[62:52] = 11'(32'd1023 + $urandom_range(0, 100) - 32'd50);
		end else if ($urandom_range(9) == 0) v[62:52] = '0;
		return v;
	endfunction

	initial begin
		logic [63:0] directed[$];
		sb = new();
		quiet_cycles = 0;
		idle_pct = 29;
		arst_n = 1'b0;
		start = 1'b0;
		value_bits = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = {64'h0, 64'h8000_0000_0000_0000, enn_pkg::ONE_BITS,
			enn_pkg::ONE_BITS - 64'd1, enn_pkg::THOUSAND_BITS,
			enn_pkg::THOUSAND_BITS - 64'd1, 64'h1, 64'h000F_FFFF_FFFF_FFFF,
			64'h0010_0000_0000_0000,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'hBFF0_0000_0000_0000,
			$realtobits(1.0e24), $realtobits(1.0e-24), $realtobits(0.5),
			$realtobits(12345.678), $realtobits(1.0e-3), $realtobits(999.9999),
			$realtobits(1.0e27), $realtobits(3.0e-27)};
		foreach (directed[i]) send_value(directed[i]);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 29 : (ph == 1) ? 45 : 0;
			for (int n = 0; n < 260; n++) send_value(random_value());
			// hold off until every result of the phase has come back
			drain();
		end

		if (sb.errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: engineering_notation_normalizer_unit.f
hdl/enn_pkg.sv
hdl/engineering_notation_normalizer_unit.sv
hdl/enn_checker.sv
sim/testbench.sv
